/* rtl/core/ledc_pkg.sv */
// shared types and constants for the addressable led chain driver
package ledc_pkg;

  localparam int PixCount     = 256;
  localparam int PixAddrW     = $clog2(PixCount);
  localparam int CountW       = 9;
  localparam int TicksW       = 10;
  localparam int WordW        = 24;
  localparam int BitsPerPixel = 24;
  localparam int BitCntW      = 5;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 10;

  localparam logic [BitCntW-1:0] LastBit     = BitCntW'(BitsPerPixel - 1);
  localparam logic [CountW-1:0]  MaxPixCount = CountW'(PixCount);

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_SEND  = 3'd3,
    OP_TICK  = 3'd4
  } ledc_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LED_COUNT  = 3'd0,
    CFG_ONE_HIGH   = 3'd1,
    CFG_ONE_LOW    = 3'd2,
    CFG_ZERO_HIGH  = 3'd3,
    CFG_ZERO_LOW   = 3'd4
  } ledc_cfg_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ledc_state_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] pixel_index;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
  } ledc_in_t;

  typedef struct packed {
    logic       data_line;
    logic       busy_res;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic       index_error;
  } ledc_out_t;

  typedef struct packed {
    logic [TicksW-1:0] one_high;
    logic [TicksW-1:0] one_low;
    logic [TicksW-1:0] zero_high;
    logic [TicksW-1:0] zero_low;
  } ledc_timing_t;

  typedef struct packed {
    logic                we;
    logic                clr;
    logic                re;
    logic [PixAddrW-1:0] waddr;
    logic [PixAddrW-1:0] raddr;
    logic [WordW-1:0]    wdata;
  } ledc_store_req_t;

  typedef struct packed {
    logic start;
    logic tick;
  } ledc_ser_ctrl_t;

  typedef struct packed {
    logic              sending;
    logic              sending_d;
    logic              high_d;
    logic [CountW-1:0] pixel_cnt;
  } ledc_ser_status_t;

endpackage

/* rtl/core/ledc_store.sv */
// pixel colour memory with per-entry valid bits and registered read
module ledc_store
  import ledc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ledc_store_req_t   req_i,
  input  logic [CountW-1:0] frame_pix_i,
  output logic [WordW-1:0]  rdata_o
);

  logic [WordW-1:0]    mem_q [PixCount];
  logic [PixCount-1:0] valid_q;
  logic [WordW-1:0]    rd_data_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  // clear only drops valid bits, an invalid entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.clr) begin
        for (int i = 0; i < PixCount; i++) begin
          if (CountW'(i) < frame_pix_i) begin
            valid_q[i] <= 1'b0;
          end
        end
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/core/ledc_serializer.sv */
// bit serializer: shifts the pixel word out msb first with pulse timing
module ledc_serializer
  import ledc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ledc_ser_ctrl_t    ctrl_i,
  input  logic [WordW-1:0]  load_data_i,
  input  ledc_timing_t      timing_i,
  input  logic [CountW-1:0] frame_pix_i,
  output ledc_ser_status_t  status_o
);

  logic [WordW-1:0]   shift_q, shift_d;
  logic [CountW-1:0]  pixel_q, pixel_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [TicksW-1:0]  phase_q, phase_d;
  logic               high_q, high_d;
  logic               sending_q, sending_d;

  logic               one_bit;
  logic [TicksW-1:0]  phase_len;
  logic [TicksW-1:0]  phase_inc;
  logic [CountW-1:0]  pixel_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      pixel_q   <= '0;
      bit_q     <= '0;
      phase_q   <= '0;
      high_q    <= 1'b0;
      sending_q <= 1'b0;
    end else begin
      shift_q   <= shift_d;
      pixel_q   <= pixel_d;
      bit_q     <= bit_d;
      phase_q   <= phase_d;
      high_q    <= high_d;
      sending_q <= sending_d;
    end
  end

  always_comb begin
    one_bit    = shift_q[WordW-1];
    if (high_q) begin
      phase_len = one_bit ? timing_i.one_high : timing_i.zero_high;
    end else begin
      phase_len = one_bit ? timing_i.one_low : timing_i.zero_low;
    end
    phase_inc  = phase_q + TicksW'(1);
    pixel_next = pixel_q + CountW'(1);

    shift_d   = shift_q;
    pixel_d   = pixel_q;
    bit_d     = bit_q;
    phase_d   = phase_q;
    high_d    = high_q;
    sending_d = sending_q;

    if (ctrl_i.start) begin
      shift_d   = load_data_i;
      pixel_d   = '0;
      bit_d     = '0;
      phase_d   = '0;
      high_d    = 1'b1;
      sending_d = 1'b1;
    end else if (ctrl_i.tick && sending_q) begin
      phase_d = phase_inc;
      // a length of zero ends the phase after one tick, same as one
      if (!(phase_inc < phase_len)) begin
        phase_d = '0;
        if (high_q) begin
          high_d = 1'b0;
        end else begin
          shift_d = {shift_q[WordW-2:0], 1'b0};
          bit_d   = bit_q + BitCntW'(1);
          high_d  = 1'b1;
          if (bit_q == LastBit) begin
            pixel_d = pixel_next;
            if (pixel_next >= frame_pix_i) begin
              sending_d = 1'b0;
              high_d    = 1'b0;
              bit_d     = '0;
              pixel_d   = '0;
              shift_d   = '0;
            end else begin
              shift_d = load_data_i;
              bit_d   = '0;
            end
          end
        end
      end
    end
  end

  assign status_o.sending   = sending_q;
  assign status_o.sending_d = sending_d;
  assign status_o.high_d    = high_d;
  assign status_o.pixel_cnt = pixel_q;

endmodule

/* rtl/core/addressable_led_chain_driver.sv */
// top level: command decode, config registers, pixel store and serializer
// a word is accepted in the idle state and executed in the exec state; its
// result is then presented from the output register
// a new word is stalled while one executes or while a result is held
// reset: asynchronous active low; store reads as zero, config at defaults, idle
module addressable_led_chain_driver
  import ledc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ledc_in_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ledc_out_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  ledc_state_e       state_q, state_d;
  ledc_in_t          item_q;
  ledc_out_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] led_count_q;
  ledc_timing_t      timing_q;

  logic              in_accept;
  logic              exec;
  logic              idle_cmd;
  logic              idx_ok;
  logic [CountW-1:0] frame_pix;
  logic [WordW-1:0]  rdata;
  ledc_store_req_t   store_req;
  ledc_ser_ctrl_t    ser_ctrl;
  ledc_ser_status_t  ser_status;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign exec        = (state_q == ST_EXEC);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q        <= CountW'(1);
      timing_q.one_high  <= TicksW'(40);
      timing_q.one_low   <= TicksW'(23);
      timing_q.zero_high <= TicksW'(20);
      timing_q.zero_low  <= TicksW'(43);
    end else if (cfg_we_i) begin
      unique case (ledc_cfg_e'(cfg_index_i))
        CFG_LED_COUNT: led_count_q        <= cfg_wdata_i[CountW-1:0];
        CFG_ONE_HIGH:  timing_q.one_high  <= cfg_wdata_i[TicksW-1:0];
        CFG_ONE_LOW:   timing_q.one_low   <= cfg_wdata_i[TicksW-1:0];
        CFG_ZERO_HIGH: timing_q.zero_high <= cfg_wdata_i[TicksW-1:0];
        CFG_ZERO_LOW:  timing_q.zero_low  <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (led_count_q == '0) begin
      frame_pix = CountW'(1);
    end else if (led_count_q > MaxPixCount) begin
      frame_pix = MaxPixCount;
    end else begin
      frame_pix = led_count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_word_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign idle_cmd = exec && !ser_status.sending;
  assign idx_ok   = {1'b0, item_q.pixel_index} < MaxPixCount;

  // store port: read at accept, write and clear while executing
  always_comb begin
    store_req.re    = in_accept;
    store_req.we    = idle_cmd && (item_q.operation == OP_WRITE) && idx_ok;
    store_req.clr   = idle_cmd && (item_q.operation == OP_CLEAR);
    store_req.waddr = item_q.pixel_index[PixAddrW-1:0];
    store_req.wdata = {item_q.green_value, item_q.red_value, item_q.blue_value};
    // tick prefetches the next pixel for a possible word boundary
    if (in_word_i.operation == OP_READ) begin
      store_req.raddr = in_word_i.pixel_index[PixAddrW-1:0];
    end else if (in_word_i.operation == OP_SEND) begin
      store_req.raddr = '0;
    end else begin
      store_req.raddr = PixAddrW'(ser_status.pixel_cnt + CountW'(1));
    end
  end

  assign ser_ctrl.start = idle_cmd && (item_q.operation == OP_SEND);
  assign ser_ctrl.tick  = exec && (item_q.operation == OP_TICK);

  ledc_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (store_req),
    .frame_pix_i (frame_pix),
    .rdata_o     (rdata)
  );

  ledc_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ser_ctrl),
    .load_data_i (rdata),
    .timing_i    (timing_q),
    .frame_pix_i (frame_pix),
    .status_o    (ser_status)
  );

  // next state and result word
  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d              = ST_IDLE;
        out_valid_d          = 1'b1;
        out_d.data_line      = ser_status.sending_d && ser_status.high_d;
        out_d.busy_res       = ser_status.sending_d;
        out_d.read_red       = '0;
        out_d.read_green     = '0;
        out_d.read_blue      = '0;
        out_d.index_error    = 1'b0;
        if (idle_cmd && ((item_q.operation == OP_WRITE) ||
                         (item_q.operation == OP_READ))) begin
          out_d.index_error = !idx_ok;
        end
        if (idle_cmd && (item_q.operation == OP_READ) && idx_ok) begin
          out_d.read_green = rdata[23:16];
          out_d.read_red   = rdata[15:8];
          out_d.read_blue  = rdata[7:0];
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
